FILE: hw/rtl/tdf_pkg.sv
// Shared constants, types and the divider status struct for the
// trial-division factorizer. No dependencies.
package tdf_pkg;

   localparam int NUMBER_BITS    = 31;
   localparam int FIELD_BITS     = 31;
   localparam int EXP_BITS       = 5;
   localparam int MAX_RESULTS    = 9;
   localparam int COUNT_BITS     = 4;
   localparam int DIV_COUNT_BITS = $clog2(NUMBER_BITS + 1);

   localparam logic [EXP_BITS-1:0] EXP_MAX = 5'd31;

   typedef logic [NUMBER_BITS-1:0]    number_type;
   typedef logic [FIELD_BITS-1:0]     field_type;
   typedef logic [EXP_BITS-1:0]       exp_type;
   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [DIV_COUNT_BITS-1:0] div_count_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic       done;
      number_type quotient;
      number_type remainder;
   } div_out_type;

endpackage

FILE: hw/rtl/tdf_if.sv
// Valid/ready channels of the factorizer: request (number) and response
// (prime, exponent, last, empty_res). Depends on tdf_pkg.
interface tdf_req_if;
   logic                 valid;
   logic                 ready;
   tdf_pkg::field_type   number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface tdf_rsp_if;
   logic                 valid;
   logic                 ready;
   tdf_pkg::field_type   prime;
   tdf_pkg::exp_type     exponent;
   logic                 last;
   logic                 empty_res;

   modport source (output valid, output prime, output exponent, output last,
                   output empty_res, input ready);
   modport sink   (input valid, input prime, input exponent, input last,
                   input empty_res, output ready);
endinterface

FILE: hw/rtl/tdf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdf_pkg.
module tdf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tdf_pkg::number_type  dividend,
   input  tdf_pkg::number_type  divisor,
   output tdf_pkg::div_out_type status
);

   localparam int NB = tdf_pkg::NUMBER_BITS;

   tdf_pkg::number_type    rem_ff, rem_in;
   tdf_pkg::number_type    quo_ff, quo_in;
   tdf_pkg::number_type    dvs_ff, dvs_in;
   tdf_pkg::div_count_type cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [NB+1:0]          diff;

   // Trial subtract of the divisor from the shifted partial remainder
   assign diff = {1'b0, rem_ff, quo_ff[NB-1]} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = tdf_pkg::div_count_type'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Keep the difference when it did not borrow
         if (!diff[NB+1]) begin
            rem_in = diff[NB-1:0];
         end else begin
            rem_in = {rem_ff[NB-2:0], quo_ff[NB-1]};
         end
         quo_in = {quo_ff[NB-2:0], ~diff[NB+1]};
         cnt_in = cnt_ff - tdf_pkg::div_count_type'(1);
         if (cnt_ff == tdf_pkg::div_count_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

FILE: hw/rtl/trial_division_factorizer.sv
// Each trial division runs in the bit-serial divider; an item takes one division per
// trial divisor and per factor found, plus the moves of its results.
// Throughput: one item at a time; the next request transfer follows the move of the
// final result into the output register. Synchronous active-high reset empties the
// output register and returns the sequencer to idle.
module trial_division_factorizer (
   input logic        clock,
   input logic        reset,
   tdf_req_if.sink    req,
   tdf_rsp_if.source  rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_TAIL  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;

   logic [2:0]            state_ff, state_in;
   tdf_pkg::number_type   n_ff, n_in;
   tdf_pkg::number_type   d_ff, d_in;
   tdf_pkg::exp_type      e_ff, e_in;
   logic                  head_ff, head_in;
   tdf_pkg::count_type    count_ff, count_in;
   logic                  tail_after_ff, tail_after_in;
   tdf_pkg::number_type   cand_prime_ff, cand_prime_in;
   tdf_pkg::exp_type      cand_exp_ff, cand_exp_in;
   logic                  pend_valid_ff, pend_valid_in;
   tdf_pkg::number_type   pend_prime_ff, pend_prime_in;
   tdf_pkg::exp_type      pend_exp_ff, pend_exp_in;
   logic                  pend_empty_ff, pend_empty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tdf_pkg::field_type    rsp_prime_ff, rsp_prime_in;
   tdf_pkg::exp_type      rsp_exp_ff, rsp_exp_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  div_start;
   tdf_pkg::div_out_type  div_status;
   tdf_pkg::number_type   req_num;
   logic                  out_free;
   logic                  room;

   tdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .status   (div_status)
   );

   assign req_num   = tdf_pkg::number_type'(req.number);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign room      = count_ff < tdf_pkg::count_type'(tdf_pkg::MAX_RESULTS);
   assign div_start = (state_ff == S_START);
   assign req.ready = (state_ff == S_IDLE);

   // Sequencer: divide, strip factors, hold one result back to mark the last
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      tail_after_in = tail_after_ff;
      cand_prime_in = cand_prime_ff;
      cand_exp_in   = cand_exp_ff;
      pend_valid_in = pend_valid_ff;
      pend_prime_in = pend_prime_ff;
      pend_exp_in   = pend_exp_ff;
      pend_empty_in = pend_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_prime_in  = rsp_prime_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               n_in          = req_num;
               d_in          = tdf_pkg::number_type'(2);
               e_in          = '0;
               head_in       = 1'b1;
               count_in      = '0;
               pend_valid_in = 1'b0;
               if (req_num <= tdf_pkg::number_type'(1)) begin
                  // Zero and one give the single empty result
                  pend_valid_in = 1'b1;
                  pend_prime_in = '0;
                  pend_exp_in   = '0;
                  pend_empty_in = 1'b1;
                  state_in      = S_FINAL;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               if (head_ff && (div_status.quotient < d_ff)) begin
                  // Divisor squared exceeds the remaining value
                  state_in = S_TAIL;
               end else if (div_status.remainder == '0) begin
                  head_in  = 1'b0;
                  n_in     = div_status.quotient;
                  if (e_ff != tdf_pkg::EXP_MAX) begin
                     e_in = e_ff + tdf_pkg::exp_type'(1);
                  end
                  state_in = S_START;
               end else begin
                  head_in = 1'b1;
                  d_in    = d_ff + tdf_pkg::number_type'(1);
                  e_in    = '0;
                  if (e_ff != '0) begin
                     if (room) begin
                        cand_prime_in = d_ff;
                        cand_exp_in   = e_ff;
                        tail_after_in = 1'b0;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_TAIL;
                     end
                  end else begin
                     state_in = S_START;
                  end
               end
            end
         end
         S_TAIL: begin
            if ((n_ff > tdf_pkg::number_type'(1)) && room) begin
               cand_prime_in = n_ff;
               cand_exp_in   = tdf_pkg::exp_type'(1);
               tail_after_in = 1'b1;
               state_in      = S_EMIT;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_EMIT: begin
            // Push the held result out, then hold the new one
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_prime_in = tdf_pkg::field_type'(pend_prime_ff);
                  rsp_exp_in   = pend_exp_ff;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = pend_empty_ff;
               end
               pend_valid_in = 1'b1;
               pend_prime_in = cand_prime_ff;
               pend_exp_in   = cand_exp_ff;
               pend_empty_in = 1'b0;
               count_in      = count_ff + tdf_pkg::count_type'(1);
               state_in      = tail_after_ff ? S_FINAL : S_START;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_prime_in  = tdf_pkg::field_type'(pend_prime_ff);
               rsp_exp_in    = pend_exp_ff;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = pend_empty_ff;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         head_ff       <= 1'b1;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
      end
      n_ff          <= n_in;
      d_ff          <= d_in;
      e_ff          <= e_in;
      tail_after_ff <= tail_after_in;
      cand_prime_ff <= cand_prime_in;
      cand_exp_ff   <= cand_exp_in;
      pend_prime_ff <= pend_prime_in;
      pend_exp_ff   <= pend_exp_in;
      pend_empty_ff <= pend_empty_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.prime     = rsp_prime_ff;
   assign rsp.exponent  = rsp_exp_ff;
   assign rsp.last      = rsp_last_ff;
   assign rsp.empty_res = rsp_empty_ff;

   // The final transfer always has a held result to send
   a_final_has_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |-> pend_valid_ff)
      else $error("final state without a held result");

   // An empty result is always the last one of its number
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> rsp_last_ff)
      else $error("empty result not marked last");

   // Result count never passes the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tdf_pkg::count_type'(tdf_pkg::MAX_RESULTS))
      else $error("result count over limit");

   // Trial divisor is at least two while dividing
   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (d_ff >= tdf_pkg::number_type'(2)))
      else $error("trial divisor below two");

   // A new request is taken only with no result held back
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !pend_valid_ff)
      else $error("request taken with a held result");

endmodule
